FILE: sv/byte_range_lock_coalescer_top_macros.svh
// Assertion macros shared by the checker of the byte-range lock coalescer.
`ifndef BYTE_RANGE_LOCK_COALESCER_TOP_MACROS_SVH
`define BYTE_RANGE_LOCK_COALESCER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRLC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/brlc_pkg.sv
`default_nettype none

package brlc_pkg;

    localparam int ADDR_W = 64;
    localparam int CNT_W  = 5;

    localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] lock_offset;
        logic [ADDR_W-1:0] lock_length;
        logic              write_mode;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] merged_offset;
        logic [ADDR_W-1:0] merged_length;
        logic [CNT_W-1:0]  absorbed_count;
        logic              range_grew;
    } out_word_t;

    // One lock table entry; end_addr is exclusive.
    typedef struct packed {
        logic              valid;
        logic              wr_mode;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
    } slot_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic             hit;
        logic             found;
        logic [CNT_W-1:0] count;
    } merge_flags_t;

endpackage

`default_nettype wire

FILE: sv/brlc_cell.sv
`default_nettype none

// One table slot of the ring. It takes its neighbour's entry on a shift.
module brlc_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire brlc_pkg::cell_ctrl_t ctrl,
    input  wire brlc_pkg::slot_t     shift_in,
    input  wire logic                load_en,
    input  wire brlc_pkg::slot_t     load_data,
    output brlc_pkg::slot_t          slot_q
);

    logic                        valid_reg, valid_next;
    logic                        mode_reg, mode_next;
    logic [brlc_pkg::ADDR_W-1:0] start_reg, start_next;
    logic [brlc_pkg::ADDR_W-1:0] end_reg, end_next;

    always_comb begin
        valid_next = valid_reg;
        mode_next  = mode_reg;
        start_next = start_reg;
        end_next   = end_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.shift) begin
            valid_next = shift_in.valid;
            mode_next  = shift_in.wr_mode;
            start_next = shift_in.start_addr;
            end_next   = shift_in.end_addr;
        end else if (load_en) begin
            valid_next = 1'b1;
            mode_next  = load_data.wr_mode;
            start_next = load_data.start_addr;
            end_next   = load_data.end_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        mode_reg  <= mode_next;
        start_reg <= start_next;
        end_reg   <= end_next;
    end

    assign slot_q = '{valid: valid_reg, wr_mode: mode_reg,
                      start_addr: start_reg, end_addr: end_reg};

endmodule

`default_nettype wire

FILE: sv/brlc_merge.sv
`default_nettype none

// Compare-and-merge unit at the head of the ring. It sees one slot per cycle,
// grows the running range over every same-mode entry that overlaps or abuts it,
// counts the absorbed entries and notes the lowest reusable slot.
module brlc_merge #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        init,
    input  wire logic                        step,
    input  wire logic [brlc_pkg::ADDR_W-1:0] init_start,
    input  wire logic [brlc_pkg::ADDR_W-1:0] init_end,
    input  wire logic                        init_mode,
    input  wire brlc_pkg::slot_t             head,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] head_idx,
    output brlc_pkg::merge_flags_t           flags,
    output logic [brlc_pkg::ADDR_W-1:0]      merged_start,
    output logic [brlc_pkg::ADDR_W-1:0]      merged_end,
    output logic [$clog2(TABLE_ENTRIES)-1:0] free_idx
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [brlc_pkg::ADDR_W-1:0] start_reg, start_next;
    logic [brlc_pkg::ADDR_W-1:0] end_reg, end_next;
    logic                        mode_reg, mode_next;
    logic [brlc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        found_reg, found_next;
    logic [IDX_W-1:0]            free_reg, free_next;
    logic                        hit;

    assign hit = step && head.valid && (head.wr_mode == mode_reg) &&
                 (head.start_addr <= end_reg) && (start_reg <= head.end_addr);

    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        free_next  = free_reg;
        if (init) begin
            start_next = init_start;
            end_next   = init_end;
            mode_next  = init_mode;
            cnt_next   = '0;
            found_next = 1'b0;
            free_next  = '0;
        end else if (step) begin
            if (hit) begin
                if (head.start_addr < start_reg) begin
                    start_next = head.start_addr;
                end
                if (head.end_addr > end_reg) begin
                    end_next = head.end_addr;
                end
                if (cnt_reg != brlc_pkg::CNT_MAX) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            if (!found_reg && (!head.valid || hit)) begin
                found_next = 1'b1;
                free_next  = head_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
        end
        start_reg <= start_next;
        end_reg   <= end_next;
        mode_reg  <= mode_next;
        free_reg  <= free_next;
    end

    assign flags        = '{hit: hit, found: found_reg, count: cnt_reg};
    assign merged_start = start_reg;
    assign merged_end   = end_reg;
    assign free_idx     = free_reg;

endmodule

`default_nettype wire

FILE: sv/byte_range_lock_coalescer_top.sv
// Byte-range lock coalescer for one lock owner. The lock table lives in a ring
// of TABLE_ENTRIES cells; an insert rotates the ring once past a single
// compare-and-merge unit, which absorbs and frees every same-mode entry that
// overlaps or abuts the request, and the merged range is then written to the
// lowest free slot. An insert with a valid range is accepted, has its range
// checked, rotates the ring past the merge unit one slot at a time, and then
// stores the entry if a slot is free and posts the result; only then is the
// next word accepted. Invalid ranges and clear requests skip the rotation. A
// finished result waits in an output register, so the next word is accepted
// while the previous result is still pending. The table is empty after reset
// and needs no clearing pass.

`default_nettype none

module byte_range_lock_coalescer_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire brlc_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output brlc_pkg::out_word_t      m_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [IDX_W-1:0]            walk_cnt_reg, walk_cnt_next;
    brlc_pkg::in_word_t          in_reg, in_next;
    logic [brlc_pkg::ADDR_W-1:0] req_end_reg, req_end_next;
    logic                        merge_reg, merge_next;
    logic [1:0]                  status_reg, status_next;
    logic                        m_valid_reg, m_valid_next;
    brlc_pkg::out_word_t         m_data_reg, m_data_next;

    // Range check: the end overflows exactly when the 65-bit sum carries out.
    logic [brlc_pkg::ADDR_W:0]   sum;
    logic                        range_bad;
    logic [brlc_pkg::ADDR_W-1:0] req_end;

    assign sum = {1'b0, in_reg.lock_offset} + {1'b0, in_reg.lock_length};
    assign range_bad = (in_reg.lock_length == '0) ||
                       ((in_reg.lock_length != brlc_pkg::ALL_ONES) &&
                        sum[brlc_pkg::ADDR_W]);
    assign req_end = sum[brlc_pkg::ADDR_W] ? brlc_pkg::ALL_ONES
                                           : sum[brlc_pkg::ADDR_W-1:0];

    // The ring of cells. Cell k takes cell k+1 on a shift, and the last cell
    // takes the head entry back from the merge unit, freed if it was absorbed.
    brlc_pkg::slot_t              cell_q [TABLE_ENTRIES];
    brlc_pkg::slot_t              ring_in [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]     load_en;
    brlc_pkg::slot_t              load_data;
    brlc_pkg::cell_ctrl_t         cell_ctrl;
    brlc_pkg::slot_t              head_back;

    brlc_pkg::merge_flags_t       mflags;
    logic [brlc_pkg::ADDR_W-1:0]  merged_start;
    logic [brlc_pkg::ADDR_W-1:0]  merged_end;
    logic [IDX_W-1:0]             free_idx;
    logic                         merge_init;
    logic                         do_out;
    logic                         do_store;

    assign merge_init = (state_reg == ST_PREP) &&
                        (in_reg.op == brlc_pkg::OP_INSERT) && !range_bad;

    assign cell_ctrl.shift = (state_reg == ST_WALK);
    assign cell_ctrl.clear = (state_reg == ST_PREP) &&
                             (in_reg.op == brlc_pkg::OP_CLEAR);

    always_comb begin
        head_back       = cell_q[0];
        head_back.valid = cell_q[0].valid && !mflags.hit;
    end

    assign load_data = '{valid: 1'b1, wr_mode: in_reg.write_mode,
                         start_addr: merged_start, end_addr: merged_end};

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        if (k == TABLE_ENTRIES - 1) begin : g_tail
            assign ring_in[k] = head_back;
        end else begin : g_body
            assign ring_in[k] = cell_q[k+1];
        end

        assign load_en[k] = do_store && (free_idx == IDX_W'(k));

        brlc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .shift_in  (ring_in[k]),
            .load_en   (load_en[k]),
            .load_data (load_data),
            .slot_q    (cell_q[k])
        );
    end

    brlc_merge #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .init         (merge_init),
        .step         (state_reg == ST_WALK),
        .init_start   (in_reg.lock_offset),
        .init_end     (req_end),
        .init_mode    (in_reg.write_mode),
        .head         (cell_q[0]),
        .head_idx     (walk_cnt_reg),
        .flags        (mflags),
        .merged_start (merged_start),
        .merged_end   (merged_end),
        .free_idx     (free_idx)
    );

    // The result leaves once the output register is free; the store into the
    // table happens in the same cycle so that it is done exactly once.
    assign do_out   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign do_store = do_out && merge_reg && mflags.found;

    always_comb begin
        state_next    = state_reg;
        walk_cnt_next = walk_cnt_reg;
        in_next       = in_reg;
        req_end_next  = req_end_reg;
        merge_next    = merge_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                walk_cnt_next = '0;
                req_end_next  = req_end;
                merge_next    = 1'b0;
                status_next   = brlc_pkg::STATUS_OK;
                if (in_reg.op == brlc_pkg::OP_CLEAR) begin
                    state_next = ST_DONE;
                end else if (range_bad) begin
                    status_next = brlc_pkg::STATUS_INVALID;
                    state_next  = ST_DONE;
                end else begin
                    merge_next = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                walk_cnt_next = walk_cnt_reg + 1'b1;
                if (walk_cnt_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (do_out) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    if (!merge_reg) begin
                        m_data_next.status = status_reg;
                    end else if (!mflags.found) begin
                        m_data_next.status = brlc_pkg::STATUS_FULL;
                    end else begin
                        m_data_next.status        = brlc_pkg::STATUS_OK;
                        m_data_next.merged_offset = merged_start;
                        m_data_next.merged_length =
                            (merged_end == brlc_pkg::ALL_ONES) ? brlc_pkg::ALL_ONES
                                                               : merged_end - merged_start;
                        m_data_next.absorbed_count = mflags.count;
                        m_data_next.range_grew =
                            (merged_start != in_reg.lock_offset) ||
                            (merged_end != req_end_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            merge_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            merge_reg   <= merge_next;
        end
        walk_cnt_reg <= walk_cnt_next;
        in_reg       <= in_next;
        req_end_reg  <= req_end_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: sv/brlc_checker.sv
`default_nettype none

`include "byte_range_lock_coalescer_top_macros.svh"

// Watches the ports of the coalescer.
module brlc_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire brlc_pkg::in_word_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire brlc_pkg::out_word_t m_data
);

    // A pending result holds until it is taken.
    `BRLC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed or dropped while stalled")

    // Only one word is in work at a time, so the input closes after an accept.
    `BRLC_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted a second word while one was in work")

    // Rejected requests carry an all-zero result.
    `BRLC_ASSERT_SAME(a_reject_zero, aclk, aresetn, m_valid && (m_data.status != brlc_pkg::STATUS_OK), (m_data.status == brlc_pkg::STATUS_INVALID || m_data.status == brlc_pkg::STATUS_FULL) && m_data.merged_offset == '0 && m_data.merged_length == '0 && m_data.absorbed_count == '0 && !m_data.range_grew, "rejected result is not all zero")

    // Without an absorbed entry the stored range is the request itself.
    `BRLC_ASSERT_SAME(a_no_grow_alone, aclk, aresetn, m_valid && m_data.absorbed_count == '0, !m_data.range_grew, "range grew with nothing absorbed")

endmodule

bind byte_range_lock_coalescer_top brlc_checker u_brlc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: verif/brlc_lock_checker.sv
// Watches both channels of the lock coalescer, keeps its own copy of the lock
// table and compares every result word with the oldest prediction.
module brlc_lock_checker
    import brlc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        fail_count,
    output int        pending,
    output int        results_checked,
    output int        full_seen,
    output int        invalid_seen,
    output int        merges_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic              tbl_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0] tbl_start [TABLE_ENTRIES];
    logic [ADDR_W-1:0] tbl_end   [TABLE_ENTRIES];
    logic              tbl_write [TABLE_ENTRIES];

    out_word_t expected_words [$];
    int        mismatches = 0;

    assign fail_count = mismatches;

    // Applies one request to the local lock table and returns the result word
    // that the block must produce for it.
    function automatic out_word_t coalesce_lock(input in_word_t req);
        out_word_t          res;
        logic [ADDR_W:0]    sum;
        logic [ADDR_W-1:0]  req_end;
        logic [ADDR_W-1:0]  n_start;
        logic [ADDR_W-1:0]  n_end;
        logic               hit [TABLE_ENTRIES];
        int                 absorbed;
        int                 free_idx;
        res      = '0;
        absorbed = 0;
        free_idx = -1;
        sum      = {1'b0, req.lock_offset} + {1'b0, req.lock_length};

        if (req.op == OP_CLEAR) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
            res.status = STATUS_OK;
            return res;
        end

        if (req.lock_length == '0 || (req.lock_length != ALL_ONES && sum[ADDR_W])) begin
            res.status = STATUS_INVALID;
            return res;
        end

        // An all-ones length runs to end of file, so the end saturates.
        req_end = sum[ADDR_W] ? ALL_ONES : sum[ADDR_W-1:0];
        n_start = req.lock_offset;
        n_end   = req_end;

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit[i] = tbl_valid[i] && tbl_write[i] == req.write_mode &&
                     tbl_start[i] <= n_end && n_start <= tbl_end[i];
            if (hit[i]) begin
                absorbed++;
                if (tbl_start[i] < n_start) n_start = tbl_start[i];
                if (tbl_end[i] > n_end) n_end = tbl_end[i];
            end
        end

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (free_idx < 0 && (!tbl_valid[i] || hit[i])) free_idx = i;
        end

        if (free_idx < 0) begin
            res.status = STATUS_FULL;
            return res;
        end

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit[i]) tbl_valid[i] = 1'b0;
        end
        tbl_valid[free_idx] = 1'b1;
        tbl_start[free_idx] = n_start;
        tbl_end[free_idx]   = n_end;
        tbl_write[free_idx] = req.write_mode;

        res.status         = STATUS_OK;
        res.merged_offset  = n_start;
        res.merged_length  = (n_end == ALL_ONES) ? ALL_ONES : n_end - n_start;
        res.absorbed_count = (absorbed > int'(CNT_MAX)) ? CNT_MAX : absorbed[CNT_W-1:0];
        res.range_grew     = (n_start != req.lock_offset) || (n_end != req_end);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got_val,
                                   input logic [ADDR_W-1:0] want_val);
        $display("MISMATCH at %0t: %s: got 0x%0h, expected 0x%0h",
                 $time, what, got_val, want_val);
        mismatches++;
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        if (expected_words.size() == 0) begin
            report_mismatch("result word with nothing expected, status",
                            ADDR_W'(got.status), '0);
            return;
        end
        want = expected_words.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", ADDR_W'(got.status), ADDR_W'(want.status));
        if (got.merged_offset !== want.merged_offset)
            report_mismatch("merged_offset", got.merged_offset, want.merged_offset);
        if (got.merged_length !== want.merged_length)
            report_mismatch("merged_length", got.merged_length, want.merged_length);
        if (got.absorbed_count !== want.absorbed_count)
            report_mismatch("absorbed_count", ADDR_W'(got.absorbed_count),
                            ADDR_W'(want.absorbed_count));
        if (got.range_grew !== want.range_grew)
            report_mismatch("range_grew", ADDR_W'(got.range_grew), ADDR_W'(want.range_grew));
        results_checked++;
        if (want.status == STATUS_FULL) full_seen++;
        if (want.status == STATUS_INVALID) invalid_seen++;
        if (want.absorbed_count != '0) merges_seen++;
    endtask

    initial begin
        pending         = 0;
        results_checked = 0;
        full_seen       = 0;
        invalid_seen    = 0;
        merges_seen     = 0;
    end

    // Results are checked before the word accepted at the same edge is
    // predicted, so a result can never match its own request early.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
            expected_words.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) check_result(m_data);
            if (s_valid && s_ready) expected_words.push_back(coalesce_lock(s_data));
            pending <= expected_words.size();
        end
    end

endmodule

FILE: verif/byte_range_lock_coalescer_top_tb.sv
// Top level of the lock coalescer testbench. It produces the request words,
// shapes the handshake pressure on both channels and gives the verdict; all
// prediction and comparison is done by the checker instantiated beside the
// block.
module byte_range_lock_coalescer_top_tb;
    import brlc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int ITEMS_PER_PHASE = 455;
    localparam int NUM_PHASES    = 4;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int fail_count;
    int pending;
    int results_checked;
    int full_seen;
    int invalid_seen;
    int merges_seen;

    // Handshake pressure, changed phase by phase: the percentage of cycles in
    // which the sender idles and in which the receiver stalls.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int send_idle_by_phase [NUM_PHASES] = '{0, 51, 0, 20};
    int recv_stall_by_phase [NUM_PHASES] = '{0, 0, 51, 20};

    logic hold_go = 1'b0;
    logic hold_rx = 1'b0;

    int          items_sent = 0;
    int          phase_end = 0;
    int          cycle_count = 0;
    logic [63:0] window_base = '0;

    byte_range_lock_coalescer_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    brlc_lock_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) lock_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .full_seen       (full_seen),
        .invalid_seen    (invalid_seen),
        .merges_seen     (merges_seen)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // The receiver stalls at random, and without pause while the long hold-off
    // is running.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_rx && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, timed in its own process. The sender carries on
    // offering words meanwhile, so the block fills its output register, then
    // its working slot, and finally has to drop s_ready.
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // Watchdog: a hung handshake must not leave the run spinning forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_word_t lock_word(input logic [63:0] off, input logic [63:0] len,
                                           input logic mode);
        in_word_t w;
        w.op          = OP_INSERT;
        w.lock_offset = off;
        w.lock_length = len;
        w.write_mode  = mode;
        return w;
    endfunction

    // A clear word carries random junk in the fields that the block ignores.
    function automatic in_word_t clear_word();
        in_word_t w;
        w.op          = OP_CLEAR;
        w.lock_offset = rand64();
        w.lock_length = rand64();
        w.write_mode  = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Picks the region in which the next set of requests clusters: near the
    // bottom of the file, just below the top of the offset space, or anywhere in its lower half.
    function automatic logic [63:0] pick_window();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return ALL_ONES - 64'd2200;
            default: return rand64() >> 1;
        endcase
    endfunction

    // Mostly well-formed requests that cluster in a small window so that
    // ranges overlap, abut and merge often. The remainder is the odd cases:
    // clears, zero lengths, overflowing ends, lengths to end of file, and
    // fully random words that exercise every bit of both 64-bit fields.
    function automatic in_word_t make_request();
        in_word_t w;
        int       pick;
        pick = $urandom_range(0, 99);
        w = lock_word(window_base + 64'($urandom_range(0, 2047)),
                      64'($urandom_range(1, 256)), 1'($urandom_range(0, 1)));
        if (pick < 3) begin
            w = clear_word();
            window_base = pick_window();
        end else if (pick < 6) begin
            w.lock_length = '0;
        end else if (pick < 9) begin
            w.lock_offset = rand64() | (64'd1 << 63);
            w.lock_length = rand64() | (64'd1 << 63);
        end else if (pick < 13) begin
            w.lock_length = ALL_ONES;
        end else if (pick < 18) begin
            w.lock_offset = rand64();
            w.lock_length = rand64();
        end else if (pick < 30) begin
            // Short, scattered ranges push the table towards full.
            w.lock_offset = window_base + 64'($urandom_range(0, 65535));
            w.lock_length = 64'($urandom_range(1, 4));
        end else if (pick < 36) begin
            // Wide ranges swallow several entries at once.
            w.lock_length = 64'($urandom_range(1, 4000));
        end
        return w;
    endfunction

    // Offers one word and returns at the edge on which it is accepted. The
    // valid stays high between back-to-back words, so a word that follows
    // without a gap never sees valid dropped and raised in one step.
    task automatic send_word(input in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Stops offering and waits until every predicted result has come back.
    // The extra edge lets the checker count the word accepted last.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // A well-formed fill sequence: empty the table, store more disjoint ranges
    // than it has slots so that the last ones come back as table full, then
    // one wide range that absorbs every same-mode entry it covers.
    task automatic fill_burst();
        logic [63:0] base;
        base = pick_window();
        send_word(clear_word());
        for (int k = 0; k < TABLE_ENTRIES + 2; k++) begin
            send_word(lock_word(base + 64'(64 * k) + 64'($urandom_range(0, 20)),
                                64'($urandom_range(1, 30)), 1'($urandom_range(0, 1))));
        end
        send_word(lock_word(base + 64'($urandom_range(0, 200)),
                            64'(64 * (TABLE_ENTRIES + 2)), 1'($urandom_range(0, 1))));
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words, no idling on either side.
        send_word(clear_word());
        send_word(lock_word(64'd40, '0, 1'b0));                 // zero length
        send_word(lock_word(ALL_ONES, 64'd1, 1'b1));            // end overflows
        send_word(lock_word(64'd1, ALL_ONES, 1'b1));            // to end of file
        send_word(lock_word('0, ALL_ONES - 64'd1, 1'b0));       // largest finite range
        send_word(lock_word(ALL_ONES - 64'd1, 64'd1, 1'b1));    // last byte, merges
        send_word(clear_word());
        send_word(lock_word(64'd100, 64'd50, 1'b0));
        send_word(lock_word(64'd150, 64'd10, 1'b0));            // abuts from above
        send_word(lock_word(64'd120, 64'd100, 1'b1));           // other mode, kept apart
        send_word(lock_word('0, 64'd100, 1'b0));                // abuts from below
        for (int i = 0; i < TABLE_ENTRIES - 2; i++) begin
            send_word(lock_word(64'd1000 + 64'(100 * i), 64'd10, i[0]));
        end
        send_word(lock_word(64'd5000, 64'd5, 1'b0));            // table full
        send_word(lock_word('0, 64'd3000, 1'b0));               // absorbs in a full table
        drain();

        // Random words in four pressure phases, each of at least ITEMS_PER_PHASE
        // words, as a fill burst may run past the end. The sender stops between phases
        // until every outstanding result has been returned.
        window_base = pick_window();
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = send_idle_by_phase[p];
            recv_stall_pct = recv_stall_by_phase[p];
            if (p == 1) hold_go = 1'b1;
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 29) == 0) fill_burst();
                else send_word(make_request());
            end
            drain();
        end

        repeat (50) @(posedge aclk);
        $display("Sent %0d request words over four idle and stall mixes plus a long output",
                 items_sent);
        $display("hold-off; %0d results checked, %0d full, %0d invalid, %0d with merges.",
                 results_checked, full_seen, invalid_seen, merges_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing.", fail_count, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
